[hdl/sobel_gradient_direction_core_assert.svh]
// Assertion macros shared by the Sobel gradient direction RTL
`ifndef SOBEL_GRADIENT_DIRECTION_CORE_ASSERT_SVH
`define SOBEL_GRADIENT_DIRECTION_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SGD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sgd_pkg.sv]
// Types and constants for the Sobel gradient direction core
package sgd_pkg;

  // register map
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int LW_W   = 11;
  localparam int FH_W   = 13;
  localparam int CFG_W  = 13;
  localparam logic [LW_W-1:0] LW_RST = 11'd1024;
  localparam logic [FH_W-1:0] FH_RST = 13'd1024;

  // payload widths
  localparam int PIX_W  = 8;
  localparam int MAG_W  = 11;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int GRAD_W = 11;   // signed gx, gy
  localparam int ABS_W  = 10;   // |gx|, |gy| up to 1020
  localparam int SQ_W   = 20;   // one square
  localparam int SUM_W  = 21;   // gx^2 + gy^2
  localparam int OUT_W  = 48;

  typedef enum logic [1:0] {
    DIR_EAST      = 2'd0,
    DIR_NORTHEAST = 2'd1,
    DIR_NORTH     = 2'd2,
    DIR_NORTHWEST = 2'd3
  } dir_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_MUL   = 5'b00100,
    S_ROOT  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_e;

endpackage

[hdl/sgd_ram.sv]
// Generic single-clock RAM, one write and one registered read port
module sgd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sgd_isqrt.sv]
// Iterative integer square root, one result bit per cycle
module sgd_isqrt
  import sgd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] operand_i,
  output logic             done_o,
  output logic [MAG_W-1:0] root_o
);

  logic [SUM_W:0]   rem_q, rem_d, res_q, res_d, bit_q, bit_d, trial;
  logic             busy_q, busy_d, done_q, done_d;

  // digit-by-digit recurrence on bit pairs
  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = res_q + bit_q;
    if (start_i) begin
      rem_d  = {1'b0, operand_i};
      res_d  = '0;
      bit_d  = (SUM_W+1)'(1) << (SUM_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[MAG_W-1:0];

endmodule

[hdl/sobel_gradient_direction_core.sv]
// Sobel 3x3 gradient magnitude and direction core (top level)
//
//  channel  dir  handshake          payload
//  s_axis   in   tvalid/tready      tdata: pixel; tuser: start_of_frame
//  m_axis   out  tvalid/tready      tdata: mag,dir,row,col,max; tlast: last_of_frame
//  cfg      in   cfg_we_i           cfg_idx_i selects register, cfg_data_i
//
// Every pixel goes through a line store read; a pixel with a result then
// takes three passes of the shared 10x10 multiplier, 11 steps of the square
// root unit plus its registered done flag, then a load of the output
// register. No new pixel is taken until the current one is done.
// Reset clears counters, window and running maximum; line stores are not
// cleared. A stalled output holds the next result in its final state.
module sobel_gradient_direction_core
  import sgd_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] pixel
  input  logic             s_axis_tuser,   // [0] start_of_frame
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [10:0] magnitude, [12:11] direction, [24:13] out_row,
  // [34:25] out_col, [45:35] frame_max, [47:46] zero
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  `include "sobel_gradient_direction_core_assert.svh"

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WC0  = $clog2(MAX_WIDTH + 1);
  localparam int HC0  = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP = (WC0 > LW_W) ? WC0 : LW_W;
  localparam int HCMP = (HC0 > FH_W) ? HC0 : FH_W;
  localparam logic [WCMP-1:0] W_MAX = WCMP'(MAX_WIDTH);
  localparam logic [HCMP-1:0] H_MAX = HCMP'(MAX_HEIGHT);
  localparam logic [WCMP-1:0] W_MIN = WCMP'(3);
  localparam logic [HCMP-1:0] H_MIN = HCMP'(3);

  state_e state_q, state_d;

  // configuration
  logic [LW_W-1:0] lw_q;
  logic [FH_W-1:0] fh_q;
  logic [WCMP-1:0] lw_ext, eff_w;
  logic [HCMP-1:0] fh_ext, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= LW_RST;
      fh_q <= FH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_WIDTH:   lw_q <= cfg_data_i[LW_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lw_ext = WCMP'(lw_q);
    fh_ext = HCMP'(fh_q);
    eff_w  = (lw_ext < W_MIN) ? W_MIN : ((lw_ext > W_MAX) ? W_MAX : lw_ext);
    eff_h  = (fh_ext < H_MIN) ? H_MIN : ((fh_ext > H_MAX) ? H_MAX : fh_ext);
  end

  // position, decided at accept
  logic [CW-1:0] col_q, c_cur, cur_c_q;
  logic [RW-1:0] row_q, r_cur, cur_r_q;
  logic          accept, col_wrap, row_wrap, produce;
  logic          prod_q, last_q, wrap_q;
  logic [PIX_W-1:0] pix_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    c_cur    = s_axis_tuser ? '0 : col_q;
    r_cur    = s_axis_tuser ? '0 : row_q;
    col_wrap = (WCMP'(c_cur) + WCMP'(1)) >= eff_w;
    row_wrap = (HCMP'(r_cur) + HCMP'(1)) >= eff_h;
    produce  = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
  end

  // line stores: upper in low byte, middle in high byte
  logic [2*PIX_W-1:0] ls_rdata;
  logic               ls_we;

  assign ls_we = (state_q == S_FETCH);

  sgd_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (cur_c_q),
    .wdata_i ({pix_q, ls_rdata[2*PIX_W-1:PIX_W]}),
    .raddr_i (c_cur),
    .rdata_o (ls_rdata)
  );

  // window and gradients
  logic [PIX_W-1:0] win_q [6];
  logic [PIX_W-1:0] up, mid;
  logic [ABS_W-1:0] sl, sr, st, sb, ax, ay, ax_q, ay_q;
  logic signed [GRAD_W-1:0] gx, gy;
  logic gx_zero, same_sign, gx_zero_q, same_q;

  always_comb begin
    up  = ls_rdata[PIX_W-1:0];
    mid = ls_rdata[2*PIX_W-1:PIX_W];
    sl  = ABS_W'(win_q[0]) + {1'b0, win_q[1], 1'b0} + ABS_W'(win_q[2]);
    sr  = ABS_W'(up) + {1'b0, mid, 1'b0} + ABS_W'(pix_q);
    st  = ABS_W'(win_q[0]) + {1'b0, win_q[3], 1'b0} + ABS_W'(up);
    sb  = ABS_W'(win_q[2]) + {1'b0, win_q[5], 1'b0} + ABS_W'(pix_q);
    gx  = $signed({1'b0, sl}) - $signed({1'b0, sr});
    gy  = $signed({1'b0, st}) - $signed({1'b0, sb});
    ax  = gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
    ay  = gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
    gx_zero   = (gx == '0);
    same_sign = ((!gx[GRAD_W-1]) && !gx_zero) == ((!gy[GRAD_W-1]) && (gy != '0));
  end

  // shared multiplier: ax*ax, ay*ay, ax*ay
  logic [1:0]      mcnt_q;
  logic [ABS_W-1:0] mul_a, mul_b;
  logic [SQ_W-1:0] sqx_q, sqy_q, pxy_q, prod;
  logic            sq_start, sq_done;
  logic [MAG_W-1:0] root;

  always_comb begin
    mul_a = ax_q;
    mul_b = ax_q;
    case (mcnt_q)
      2'd1:    begin mul_a = ay_q; mul_b = ay_q; end
      2'd2:    begin mul_a = ax_q; mul_b = ay_q; end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  assign sq_start = (state_q == S_MUL) && (mcnt_q == 2'd2);

  sgd_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (SUM_W'(sqx_q) + SUM_W'(sqy_q)),
    .done_o    (sq_done),
    .root_o    (root)
  );

  // direction from squared terms
  logic [SUM_W:0] px2;
  logic           east, north, out_load;
  dir_e           dir;
  logic [MAG_W-1:0] mx, mag_q;

  always_comb begin
    px2   = {1'b0, pxy_q, 1'b0};
    east  = ((SUM_W+1)'(sqy_q) + px2) < (SUM_W+1)'(sqx_q);
    north = ((SUM_W+1)'(sqx_q) + px2) < (SUM_W+1)'(sqy_q);
    if (gx_zero_q)      dir = DIR_NORTH;
    else if (east)      dir = DIR_EAST;
    else if (north)     dir = DIR_NORTH;
    else if (same_q)    dir = DIR_NORTHEAST;
    else                dir = DIR_NORTHWEST;
  end

  logic [MAG_W-1:0] max_q;
  logic             m_valid_q;

  assign out_load = (state_q == S_HOLD) && (!m_valid_q || m_axis_tready);
  assign mx       = (mag_q > max_q) ? mag_q : max_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_FETCH;
      S_FETCH: state_d = prod_q ? S_MUL : S_IDLE;
      S_MUL:   if (mcnt_q == 2'd2) state_d = S_ROOT;
      S_ROOT:  if (sq_done) state_d = S_HOLD;
      S_HOLD:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      max_q     <= '0;
      mcnt_q    <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        col_q  <= col_wrap ? '0 : c_cur + CW'(1);
        row_q  <= col_wrap ? (row_wrap ? '0 : r_cur + RW'(1)) : r_cur;
        if (s_axis_tuser) max_q <= '0;
      end
      if (state_q == S_FETCH) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= up;
        win_q[4] <= mid;
        win_q[5] <= pix_q;
        if (!prod_q && wrap_q) max_q <= '0;
      end
      mcnt_q <= (state_q == S_MUL) ? mcnt_q + 2'd1 : 2'd0;
      if (out_load) begin
        max_q     <= wrap_q ? '0 : mx;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  logic [ROW_W-1:0] orow_q;
  logic [COL_W-1:0] ocol_q;
  logic [1:0]       odir_q;
  logic [MAG_W-1:0] omag_q, omax_q;
  logic             olast_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q   <= s_axis_tdata;
      cur_c_q <= c_cur;
      cur_r_q <= r_cur;
      prod_q  <= produce;
      last_q  <= col_wrap && row_wrap;
      wrap_q  <= col_wrap && row_wrap;
    end
    if (state_q == S_FETCH) begin
      ax_q      <= ax;
      ay_q      <= ay;
      gx_zero_q <= gx_zero;
      same_q    <= same_sign;
    end
    if (state_q == S_MUL) begin
      case (mcnt_q)
        2'd0:    sqx_q <= prod;
        2'd1:    sqy_q <= prod;
        default: pxy_q <= prod;
      endcase
    end
    if (sq_done) mag_q <= root;
    if (out_load) begin
      omag_q  <= mag_q;
      odir_q  <= dir;
      orow_q  <= ROW_W'(cur_r_q - RW'(1));
      ocol_q  <= COL_W'(cur_c_q - CW'(1));
      olast_q <= last_q;
      omax_q  <= last_q ? mx : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {2'b00, omax_q, ocol_q, orow_q, odir_q, omag_q};

  `SGD_ASSERT_NEXT(a_accept_fetch, accept, state_q == S_FETCH,
    "accepted pixel did not move to line store fetch")
  `SGD_ASSERT_NOW(a_root_done, sq_done, state_q == S_ROOT,
    "square root finished outside root state")
  `SGD_ASSERT_NOW(a_no_overwrite, out_load, !m_valid_q || m_axis_tready,
    "output register overwritten while stalled")
  `SGD_ASSERT_NOW(a_max_bound, m_valid_q && olast_q, omax_q >= omag_q,
    "frame maximum below final magnitude")
  `SGD_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q),
    "sequencer state lost one-hot encoding")

endmodule
